// ----- rtl/core/ptfd_pkg.sv -----
// ----------------------------------------------------------------------------
// ptfd_pkg
// Shared word format, constants, context type and fixed-point helpers for the
// proper-time field dilation pipeline.
// ----------------------------------------------------------------------------
package ptfd_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int SUM_BITS  = WORD_BITS + 3;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int ROOT_BITS = WORD_BITS + FRAC_BITS;
  localparam int SQRT_BITS = ROOT_BITS / 2;

  // Register stages: front end, root, gamma terms, four dividers, three
  // refinement orders and the output register.
  localparam int ORDER_STAGES = 6;
  localparam int PIPE_LATENCY = 6 + (SQRT_BITS + 1) + 3 + 4 * (FRAC_BITS + 1) +
                                3 * ORDER_STAGES + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  localparam word_t FX_ONE       = word_t'(64'd1 << FRAC_BITS);
  localparam word_t VMAX         = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t VMIN         = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t C_TWO_THIRDS =
    word_t'((64'd66667 * (64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam word_t C_EIGHTH     = word_t'(64'd1 << (FRAC_BITS - 3));

  // Per-particle values that ride along with the ratio refinement.
  typedef struct packed {
    logic [2:0][WORD_BITS-1:0] e;
    logic [2:0][WORD_BITS-1:0] b;
    word_t ue;
    word_t e2;
    word_t uexb;
    word_t k2;
    word_t k3;
    word_t gam;
    word_t ds0;
  } ctx_t;

  function automatic sum_t ext(input word_t v);
    return sum_t'(v);
  endfunction

  function automatic word_t sat(input sum_t v);
    if (v > ext(VMAX)) return VMAX;
    if (v < ext(VMIN)) return VMIN;
    return word_t'(v);
  endfunction

  function automatic word_t sum3(input word_t a, input word_t b, input word_t c);
    return sat(ext(a) + ext(b) + ext(c));
  endfunction

  function automatic word_t pos_part(input word_t v);
    return v[WORD_BITS-1] ? '0 : v;
  endfunction

  function automatic word_t neg_part(input word_t v);
    return v[WORD_BITS-1] ? v : '0;
  endfunction

  // Product truncated toward zero at the binary point, then saturated.
  function automatic word_t fmul(input word_t a, input word_t b);
    logic signed [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] mag;
    logic [PROD_BITS-1:0] lim;
    logic [PROD_BITS-1:0] res;
    logic neg;
    prod = a * b;
    neg  = prod[PROD_BITS-1];
    mag  = neg ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    res  = mag >> FRAC_BITS;
    lim  = (PROD_BITS'(1) << (WORD_BITS - 1)) - PROD_BITS'(!neg);
    if (res > lim) res = lim;
    return neg ? word_t'(-res) : word_t'(res);
  endfunction

endpackage

// ----- rtl/core/ptfd_div.sv -----
// ----------------------------------------------------------------------------
// ptfd_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// min(num / den, 1.0) for num >= 0 and den >= 1.0, with a side payload.
// ----------------------------------------------------------------------------
module ptfd_div import ptfd_pkg::*; #(
  parameter int CARRY_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  word_t              in_num,
  input  word_t              in_den,
  input  logic [CARRY_W-1:0] in_carry,
  output logic               out_v,
  output word_t              out_q,
  output logic [CARRY_W-1:0] out_carry
);

  localparam int STAGES = FRAC_BITS + 1;

  logic                 v_r     [STAGES];
  logic                 ge_r    [STAGES];
  logic [FRAC_BITS-1:0] q_r     [STAGES];
  logic [CARRY_W-1:0]   carry_r [STAGES];
  logic [WORD_BITS-1:0] rem_r   [STAGES-1];
  logic [WORD_BITS-1:0] den_r   [STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    ge_r[0]    <= (in_num >= in_den);
    rem_r[0]   <= in_num;
    den_r[0]   <= in_den;
    q_r[0]     <= '0;
    carry_r[0] <= in_carry;
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [WORD_BITS-1:0] dbl;
    logic                 take;

    assign dbl  = {rem_r[k-1][WORD_BITS-2:0], 1'b0};
    assign take = (dbl >= den_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      ge_r[k]    <= ge_r[k-1];
      q_r[k]     <= {q_r[k-1][FRAC_BITS-2:0], take};
      carry_r[k] <= carry_r[k-1];
    end

    if (k < STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? (dbl - den_r[k-1]) : dbl;
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign out_v     = v_r[STAGES-1];
  assign out_carry = carry_r[STAGES-1];
  assign out_q     = ge_r[STAGES-1] ? FX_ONE :
                     word_t'({{(WORD_BITS-FRAC_BITS){1'b0}}, q_r[STAGES-1]});

endmodule

// ----- rtl/core/ptfd_sqrt.sv -----
// ----------------------------------------------------------------------------
// ptfd_sqrt
// Pipelined square root, one result bit per stage by trial squaring.
// Gives floor(sqrt(s)) at the word's binary point, saturated, with a payload.
// ----------------------------------------------------------------------------
module ptfd_sqrt import ptfd_pkg::*; #(
  parameter int CARRY_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_v,
  input  word_t              in_s,
  input  logic [CARRY_W-1:0] in_carry,
  output logic               out_v,
  output word_t              out_gam,
  output logic [CARRY_W-1:0] out_carry
);

  localparam int STAGES   = SQRT_BITS + 1;
  localparam int SQR_BITS = 2 * SQRT_BITS;

  logic                 v_r     [STAGES];
  logic [SQRT_BITS-1:0] root_r  [STAGES];
  logic [CARRY_W-1:0]   carry_r [STAGES];
  logic [ROOT_BITS-1:0] tgt_r   [STAGES-1];
  logic [WORD_BITS:0]   root_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r[0]   <= {in_s, {FRAC_BITS{1'b0}}};
    root_r[0]  <= '0;
    carry_r[0] <= in_carry;
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [SQRT_BITS-1:0] cand;
    logic [SQR_BITS-1:0]  sqr;
    logic                 fit;

    assign cand = root_r[k-1] | (SQRT_BITS'(1) << (SQRT_BITS - k));
    assign sqr  = cand * cand;
    assign fit  = (ROOT_BITS'(sqr) <= tgt_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      root_r[k]  <= fit ? cand : root_r[k-1];
      carry_r[k] <= carry_r[k-1];
    end

    if (k < STAGES - 1) begin : g_tgt
      always_ff @(posedge clk) begin
        tgt_r[k] <= tgt_r[k-1];
      end
    end
  end

  assign root_x    = (WORD_BITS+1)'(root_r[STAGES-1]);
  assign out_v     = v_r[STAGES-1];
  assign out_carry = carry_r[STAGES-1];
  assign out_gam   = (root_x > (WORD_BITS+1)'(VMAX)) ? VMAX : word_t'(root_x);

endmodule

// ----- rtl/core/proper_time_field_dilation_core.sv -----
// ----------------------------------------------------------------------------
// proper_time_field_dilation_core
// Datapath: the 25-stage square root and the four 17-stage dividers lie in
// series between the accepting edge and the out_valid strobe.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: synchronous, active low, clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
module proper_time_field_dilation_core import ptfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] in_mom_x,
  input  logic [WORD_BITS-1:0] in_mom_y,
  input  logic [WORD_BITS-1:0] in_mom_z,
  input  logic [WORD_BITS-1:0] in_efield_x,
  input  logic [WORD_BITS-1:0] in_efield_y,
  input  logic [WORD_BITS-1:0] in_efield_z,
  input  logic [WORD_BITS-1:0] in_bfield_x,
  input  logic [WORD_BITS-1:0] in_bfield_y,
  input  logic [WORD_BITS-1:0] in_bfield_z,
  output logic                 out_valid,
  output logic [WORD_BITS-2:0] out_gamma,
  output logic [WORD_BITS-1:0] out_dil_efield_x,
  output logic [WORD_BITS-1:0] out_dil_efield_y,
  output logic [WORD_BITS-1:0] out_dil_efield_z,
  output logic [WORD_BITS-1:0] out_dil_bfield_x,
  output logic [WORD_BITS-1:0] out_dil_bfield_y,
  output logic [WORD_BITS-1:0] out_dil_bfield_z
);

  word_t in_u [3];
  word_t in_e [3];
  word_t in_b [3];

  assign in_u[0] = in_mom_x;
  assign in_u[1] = in_mom_y;
  assign in_u[2] = in_mom_z;
  assign in_e[0] = in_efield_x;
  assign in_e[1] = in_efield_y;
  assign in_e[2] = in_efield_z;
  assign in_b[0] = in_bfield_x;
  assign in_b[1] = in_bfield_y;
  assign in_b[2] = in_bfield_z;

  assign busy = 1'b0;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;
  logic out_valid_r;

  // Stage 1: all first-level products.
  word_t s1_u_r [3], s1_e_r [3], s1_b_r [3];
  word_t s1_uu_r [3], s1_ue_r [3], s1_ub_r [3], s1_eb_r [3], s1_ee_r [3], s1_bb_r [3];
  word_t s1_cp_r [3], s1_cn_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_u_r[i]  <= in_u[i];
      s1_e_r[i]  <= in_e[i];
      s1_b_r[i]  <= in_b[i];
      s1_uu_r[i] <= fmul(in_u[i], in_u[i]);
      s1_ue_r[i] <= fmul(in_u[i], in_e[i]);
      s1_ub_r[i] <= fmul(in_u[i], in_b[i]);
      s1_eb_r[i] <= fmul(in_e[i], in_b[i]);
      s1_ee_r[i] <= fmul(in_e[i], in_e[i]);
      s1_bb_r[i] <= fmul(in_b[i], in_b[i]);
    end
    s1_cp_r[0] <= fmul(in_e[1], in_b[2]);
    s1_cn_r[0] <= fmul(in_e[2], in_b[1]);
    s1_cp_r[1] <= fmul(in_e[2], in_b[0]);
    s1_cn_r[1] <= fmul(in_e[0], in_b[2]);
    s1_cp_r[2] <= fmul(in_e[0], in_b[1]);
    s1_cn_r[2] <= fmul(in_e[1], in_b[0]);
  end

  // Stage 2: dot products and the cross product.
  word_t s2_u_r [3], s2_e_r [3], s2_b_r [3], s2_c_r [3];
  word_t s2_s_r, s2_ue_r, s2_ub_r, s2_eb_r, s2_e2_r, s2_b2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_u_r[i] <= s1_u_r[i];
      s2_e_r[i] <= s1_e_r[i];
      s2_b_r[i] <= s1_b_r[i];
      s2_c_r[i] <= sat(ext(s1_cp_r[i]) - ext(s1_cn_r[i]));
    end
    s2_s_r  <= sat(ext(FX_ONE) + ext(s1_uu_r[0]) + ext(s1_uu_r[1]) + ext(s1_uu_r[2]));
    s2_ue_r <= sum3(s1_ue_r[0], s1_ue_r[1], s1_ue_r[2]);
    s2_ub_r <= sum3(s1_ub_r[0], s1_ub_r[1], s1_ub_r[2]);
    s2_eb_r <= sum3(s1_eb_r[0], s1_eb_r[1], s1_eb_r[2]);
    s2_e2_r <= sum3(s1_ee_r[0], s1_ee_r[1], s1_ee_r[2]);
    s2_b2_r <= sum3(s1_bb_r[0], s1_bb_r[1], s1_bb_r[2]);
  end

  // Stage 3.
  word_t s3_e_r [3], s3_b_r [3], s3_uc_r [3];
  word_t s3_s_r, s3_ue_r, s3_e2_r, s3_d_r, s3_ubeb_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_e_r[i]  <= s2_e_r[i];
      s3_b_r[i]  <= s2_b_r[i];
      s3_uc_r[i] <= fmul(s2_u_r[i], s2_c_r[i]);
    end
    s3_s_r    <= s2_s_r;
    s3_ue_r   <= s2_ue_r;
    s3_e2_r   <= s2_e2_r;
    s3_d_r    <= sat(ext(s2_e2_r) - ext(s2_b2_r));
    s3_ubeb_r <= fmul(s2_ub_r, s2_eb_r);
  end

  // Stage 4.
  word_t s4_e_r [3], s4_b_r [3];
  word_t s4_s_r, s4_ue_r, s4_e2_r, s4_uexb_r, s4_t_r, s4_ubeb2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_e_r[i] <= s3_e_r[i];
      s4_b_r[i] <= s3_b_r[i];
    end
    s4_s_r     <= s3_s_r;
    s4_ue_r    <= s3_ue_r;
    s4_e2_r    <= s3_e2_r;
    s4_uexb_r  <= sum3(s3_uc_r[0], s3_uc_r[1], s3_uc_r[2]);
    s4_t_r     <= fmul(s3_ue_r, s3_d_r);
    s4_ubeb2_r <= sat(ext(s3_ubeb_r) + ext(s3_ubeb_r));
  end

  // Stage 5.
  word_t s5_e_r [3], s5_b_r [3];
  word_t s5_s_r, s5_ue_r, s5_e2_r, s5_uexb_r, s5_k3a_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s5_e_r[i] <= s4_e_r[i];
      s5_b_r[i] <= s4_b_r[i];
    end
    s5_s_r    <= s4_s_r;
    s5_ue_r   <= s4_ue_r;
    s5_e2_r   <= s4_e2_r;
    s5_uexb_r <= s4_uexb_r;
    s5_k3a_r  <= sat(ext(sum3(s4_t_r, s4_t_r, s4_t_r)) + ext(s4_ubeb2_r));
  end

  // Stage 6: third-order coefficient; the context is packed for the root.
  word_t s6_s_r;
  ctx_t  s6_ctx_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s6_ctx_r.e[i] <= s5_e_r[i];
      s6_ctx_r.b[i] <= s5_b_r[i];
    end
    s6_s_r        <= s5_s_r;
    s6_ctx_r.ue   <= s5_ue_r;
    s6_ctx_r.e2   <= s5_e2_r;
    s6_ctx_r.uexb <= s5_uexb_r;
    s6_ctx_r.k3   <= fmul(C_EIGHTH, s5_k3a_r);
    s6_ctx_r.k2   <= '0;
    s6_ctx_r.gam  <= '0;
    s6_ctx_r.ds0  <= '0;
  end

  logic  sq_v;
  word_t sq_gam;
  ctx_t  sq_ctx;

  ptfd_sqrt #(
    .CARRY_W ($bits(ctx_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (s6_v_r),
    .in_s      (s6_s_r),
    .in_carry  (s6_ctx_r),
    .out_v     (sq_v),
    .out_gam   (sq_gam),
    .out_carry (sq_ctx)
  );

  // Stages 7 to 9: second-order coefficient from gamma.
  ctx_t  s7_ctx_r, s8_ctx_r, s9_ctx_r;
  ctx_t  s7_ctx_nxt, s9_ctx_nxt;
  word_t s7_gm_r, s8_k2a_r;

  always_comb begin
    s7_ctx_nxt     = sq_ctx;
    s7_ctx_nxt.gam = sq_gam;
    s9_ctx_nxt     = s8_ctx_r;
    s9_ctx_nxt.k2  = fmul(C_TWO_THIRDS, s8_k2a_r);
  end

  always_ff @(posedge clk) begin
    s7_ctx_r     <= s7_ctx_nxt;
    s7_gm_r      <= fmul(sq_gam, sq_ctx.e2);
    s8_ctx_r     <= s7_ctx_r;
    s8_k2a_r     <= sat(ext(s7_gm_r) - ext(s7_ctx_r.uexb));
    s9_ctx_r     <= s9_ctx_nxt;
  end

  // Divider 0 forms 1/gamma; dividers 1 to 3 close each refinement order.
  logic  dn_v   [4];
  word_t dn_num [4];
  word_t dn_den [4];
  ctx_t  dn_ctx [4];
  logic  dv_v   [4];
  word_t dv_q   [4];
  ctx_t  dv_ctx [4];

  assign dn_v[0]   = s9_v_r;
  assign dn_num[0] = FX_ONE;
  assign dn_den[0] = s9_ctx_r.gam;
  assign dn_ctx[0] = s9_ctx_r;

  for (genvar k = 0; k < 4; k++) begin : g_div
    ptfd_div #(
      .CARRY_W ($bits(ctx_t))
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_v      (dn_v[k]),
      .in_num    (dn_num[k]),
      .in_den    (dn_den[k]),
      .in_carry  (dn_ctx[k]),
      .out_v     (dv_v[k]),
      .out_q     (dv_q[k]),
      .out_carry (dv_ctx[k])
    );
  end

  // One refinement order: t from powers of the previous ratio, then the
  // numerator and denominator of the next ratio. The first order has no k2
  // term and only the third has a k3 term.
  for (genvar g = 0; g < 3; g++) begin : g_order
    logic  o1_v_r, o2_v_r, o3_v_r, o4_v_r, o5_v_r, o6_v_r;
    ctx_t  o1_ctx_r, o2_ctx_r, o3_ctx_r, o4_ctx_r, o5_ctx_r, o6_ctx_r;
    ctx_t  o1_ctx_nxt;
    word_t o1_ds_r, o1_sq_r;
    word_t o2_cube_r, o2_quad_r, o2_p1_r;
    word_t o3_p1_r, o3_p2_r, o3_p3_r;
    word_t o4_t_r;
    word_t o5_a_r, o5_den_r;
    word_t o6_num_r, o6_den_r;
    word_t k2_sel, k3_sel;

    assign k2_sel = (g >= 1) ? o2_ctx_r.k2 : '0;
    assign k3_sel = (g == 2) ? o2_ctx_r.k3 : '0;

    // The first order captures 1/gamma as the base ratio for all orders.
    always_comb begin
      o1_ctx_nxt = dv_ctx[g];
      if (g == 0) begin
        o1_ctx_nxt.ds0 = dv_q[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        o1_v_r <= 1'b0;
        o2_v_r <= 1'b0;
        o3_v_r <= 1'b0;
        o4_v_r <= 1'b0;
        o5_v_r <= 1'b0;
        o6_v_r <= 1'b0;
      end else begin
        o1_v_r <= dv_v[g];
        o2_v_r <= o1_v_r;
        o3_v_r <= o2_v_r;
        o4_v_r <= o3_v_r;
        o5_v_r <= o4_v_r;
        o6_v_r <= o5_v_r;
      end
    end

    always_ff @(posedge clk) begin
      o1_ctx_r  <= o1_ctx_nxt;
      o1_ds_r   <= dv_q[g];
      o1_sq_r   <= fmul(dv_q[g], dv_q[g]);

      o2_ctx_r  <= o1_ctx_r;
      o2_cube_r <= fmul(o1_sq_r, o1_ds_r);
      o2_quad_r <= fmul(o1_sq_r, o1_sq_r);
      o2_p1_r   <= fmul(o1_ctx_r.ue, o1_sq_r);

      o3_ctx_r  <= o2_ctx_r;
      o3_p1_r   <= o2_p1_r;
      o3_p2_r   <= fmul(k2_sel, o2_cube_r);
      o3_p3_r   <= fmul(k3_sel, o2_quad_r);

      o4_ctx_r  <= o3_ctx_r;
      o4_t_r    <= sum3(o3_p1_r, o3_p2_r, o3_p3_r);

      o5_ctx_r  <= o4_ctx_r;
      o5_a_r    <= sat(ext(FX_ONE) - ext(neg_part(o4_t_r)));
      o5_den_r  <= sat(ext(FX_ONE) + ext(pos_part(o4_t_r)));

      o6_ctx_r  <= o5_ctx_r;
      o6_num_r  <= fmul(o5_ctx_r.ds0, o5_a_r);
      o6_den_r  <= o5_den_r;
    end

    assign dn_v[g+1]   = o6_v_r;
    assign dn_num[g+1] = o6_num_r;
    assign dn_den[g+1] = o6_den_r;
    assign dn_ctx[g+1] = o6_ctx_r;
  end

  // Output register.
  logic [WORD_BITS-2:0] out_gamma_r;
  word_t                dil_e_r [3];
  word_t                dil_b_r [3];

  always_ff @(posedge clk) begin
    out_gamma_r <= dv_ctx[3].gam[WORD_BITS-2:0];
    for (int i = 0; i < 3; i++) begin
      dil_e_r[i] <= fmul(word_t'(dv_ctx[3].e[i]), dv_q[3]);
      dil_b_r[i] <= fmul(word_t'(dv_ctx[3].b[i]), dv_q[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      s7_v_r      <= 1'b0;
      s8_v_r      <= 1'b0;
      s9_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= start && !busy;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r;
      s6_v_r      <= s5_v_r;
      s7_v_r      <= sq_v;
      s8_v_r      <= s7_v_r;
      s9_v_r      <= s8_v_r;
      out_valid_r <= dv_v[3];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gamma        = out_gamma_r;
  assign out_dil_efield_x = dil_e_r[0];
  assign out_dil_efield_y = dil_e_r[1];
  assign out_dil_efield_z = dil_e_r[2];
  assign out_dil_bfield_x = dil_b_r[0];
  assign out_dil_bfield_y = dil_b_r[1];
  assign out_dil_bfield_z = dil_b_r[2];

endmodule

// ----- rtl/core/ptfd_checker.sv -----
// ----------------------------------------------------------------------------
// ptfd_checker
// Port-level checks for the dilation core: fixed latency, no spurious
// results, no backpressure and a physical Lorentz factor.
// ----------------------------------------------------------------------------
module ptfd_checker import ptfd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [WORD_BITS-2:0] out_gamma
);

  // Every accepted transaction produces exactly one result after the latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_valid)
    else $error("result missing after accepted transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LATENCY !out_valid)
    else $error("result without a matching transaction");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised on a fully pipelined core");

  a_gamma_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gamma >= (WORD_BITS-1)'(FX_ONE)))
    else $error("gamma below one");

endmodule

bind proper_time_field_dilation_core ptfd_checker u_ptfd_checker (.*);
